// ===== rtl/rmtp_pkg.sv =====
package rmtp_pkg;

  // Largest area the block handles.
  localparam int unsigned MAX_COLUMNS = 128;
  localparam int unsigned MAX_ROWS    = 64;

  // Field and register widths.
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned WIDTH_W  = 8;
  localparam int unsigned HEIGHT_W = 7;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_TDATA_W = 24;

  // Counter widths: _W indexes a position, N_W holds the count itself.
  localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
  localparam int unsigned COLN_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ROWN_W = $clog2(MAX_ROWS + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  // Threshold: gray = sum/3 > 128 is sum >= 387.
  localparam logic [9:0] SUM_ON_MIN = 10'd387;

  // Pixel beat held in the input register.
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] color;
  } pix_t;

  // Result beat held in the output register.
  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic [OFF_W-1:0]  byte_offset;
    logic              last_of_area;
  } res_t;

  // v * 255 / 7, truncated.
  function automatic logic [7:0] scale3(input logic [2:0] v);
    logic [7:0] s;
    case (v)
      3'd0:    s = 8'd0;
      3'd1:    s = 8'd36;
      3'd2:    s = 8'd72;
      3'd3:    s = 8'd109;
      3'd4:    s = 8'd145;
      3'd5:    s = 8'd182;
      3'd6:    s = 8'd218;
      3'd7:    s = 8'd255;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  // v * 255 / 3.
  function automatic logic [7:0] scale2(input logic [1:0] v);
    logic [7:0] s;
    case (v)
      2'd0:    s = 8'd0;
      2'd1:    s = 8'd85;
      2'd2:    s = 8'd170;
      2'd3:    s = 8'd255;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic logic pixel_on(input logic [PIX_W-1:0] c);
    logic [9:0] sum;
    sum = 10'(scale3(c[7:5])) + 10'(scale3(c[4:2])) + 10'(scale2(c[1:0]));
    return sum >= SUM_ON_MIN;
  endfunction

  function automatic logic [COLN_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    logic [COLN_W-1:0] r;
    if (v == '0) begin
      r = COLN_W'(1);
    end else if (32'(v) > MAX_COLUMNS) begin
      r = COLN_W'(MAX_COLUMNS);
    end else begin
      r = COLN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ROWN_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    logic [ROWN_W-1:0] r;
    if (v == '0) begin
      r = ROWN_W'(1);
    end else if (32'(v) > MAX_ROWS) begin
      r = ROWN_W'(MAX_ROWS);
    end else begin
      r = ROWN_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rmtp_in_stage.sv =====
module rmtp_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rmtp_pkg::PIX_W-1:0] s_axis_tdata,
  input  logic                       advance_i,   // packer takes the held pixel
  output rmtp_pkg::pix_t             pix_o
);

  logic                       valid_q, valid_d;
  logic [rmtp_pkg::PIX_W-1:0] color_q;

  // Register frees up when empty or when its content moves on this cycle.
  assign s_axis_tready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      color_q <= s_axis_tdata;
    end
  end

  assign pix_o.valid = valid_q;
  assign pix_o.color = color_q;

endmodule

// ===== rtl/rmtp_packer.sv =====
module rmtp_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmtp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rmtp_pkg::CFG_W-1:0]     cfg_data_i,
  input  rmtp_pkg::pix_t                 pix_i,
  input  logic                           out_ready_i,
  output logic                           advance_o,
  output logic                           out_valid_o,
  output rmtp_pkg::res_t                 res_o
);

  logic [rmtp_pkg::WIDTH_W-1:0]  width_q;
  logic [rmtp_pkg::HEIGHT_W-1:0] height_q;
  logic [rmtp_pkg::COL_W-1:0]    col_q, col_d;
  logic [rmtp_pkg::ROW_W-1:0]    row_q, row_d;
  logic [rmtp_pkg::BYTE_W-1:0]   part_q, part_d;
  logic [rmtp_pkg::OFF_W-1:0]    off_q, off_d;
  logic                          out_valid_q, out_valid_d;
  rmtp_pkg::res_t                res_q;

  logic [rmtp_pkg::COLN_W-1:0]   w;
  logic [rmtp_pkg::ROWN_W-1:0]   h;
  logic [rmtp_pkg::BYTE_W-1:0]   gathered;
  logic                          take, row_end, byte_end, area_end, cfg_clear;

  assign advance_o = !out_valid_q || out_ready_i;
  assign take      = pix_i.valid && advance_o;
  assign cfg_clear = cfg_we_i &&
                     (cfg_idx_i == rmtp_pkg::REG_WIDTH ||
                      cfg_idx_i == rmtp_pkg::REG_HEIGHT);

  assign w = rmtp_pkg::clamp_width(width_q);
  assign h = rmtp_pkg::clamp_height(height_q);

  assign row_end  = (rmtp_pkg::COLN_W'(col_q) + rmtp_pkg::COLN_W'(1)) >= w;
  assign byte_end = (col_q[2:0] == 3'd7) || row_end;
  assign area_end = row_end &&
                    ((rmtp_pkg::ROWN_W'(row_q) + rmtp_pkg::ROWN_W'(1)) >= h);

  // Leftmost pixel lands in bit 7.
  assign gathered = rmtp_pkg::pixel_on(pix_i.color) ?
                    (part_q | (8'h80 >> col_q[2:0])) : part_q;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    part_d      = part_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cfg_clear) begin
      col_d  = '0;
      row_d  = '0;
      part_d = '0;
      off_d  = '0;
    end else if (take) begin
      if (!byte_end) begin
        part_d = gathered;
        col_d  = col_q + rmtp_pkg::COL_W'(1);
      end else begin
        out_valid_d = 1'b1;
        part_d      = '0;
        if (area_end) begin
          col_d = '0;
          row_d = '0;
          off_d = '0;
        end else begin
          off_d = off_q + rmtp_pkg::OFF_W'(1);
          if (row_end) begin
            col_d = '0;
            row_d = row_q + rmtp_pkg::ROW_W'(1);
          end else begin
            col_d = col_q + rmtp_pkg::COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= rmtp_pkg::WIDTH_W'(rmtp_pkg::MAX_COLUMNS);
      height_q    <= rmtp_pkg::HEIGHT_W'(rmtp_pkg::MAX_ROWS);
      col_q       <= '0;
      row_q       <= '0;
      part_q      <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == rmtp_pkg::REG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == rmtp_pkg::REG_HEIGHT) begin
        height_q <= cfg_data_i[rmtp_pkg::HEIGHT_W-1:0];
      end
      col_q       <= col_d;
      row_q       <= row_d;
      part_q      <= part_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && byte_end && !cfg_clear) begin
      res_q.packed_byte  <= gathered;
      res_q.byte_offset  <= off_q;
      res_q.last_of_area <= area_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // A fresh byte always starts with no bits gathered.
  a_part_clear_at_byte_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q[2:0] == 3'd0 |-> part_q == '0)
    else $error("partial byte not clear at byte start");

  // Closing the area returns all counters to zero.
  a_area_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && byte_end && area_end && !cfg_clear |=>
      col_q == '0 && row_q == '0 && off_q == '0)
    else $error("state not cleared after last byte of area");

  // Every other emitted byte advances the offset by one.
  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && byte_end && !area_end && !cfg_clear |=>
      off_q == $past(off_q) + rmtp_pkg::OFF_W'(1))
    else $error("byte offset did not advance");

  // Column stays inside the configured row.
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> rmtp_pkg::COLN_W'(col_q) < w)
    else $error("column beyond row width");

endmodule

// ===== rtl/rgb332_mono_threshold_packer.sv =====
// rgb332_mono_threshold_packer
//
// Converts a raster-order stream of RGB332 pixels into a packed monochrome
// bitmap. A pixel is on when the average of its channels, each scaled to
// 8 bits, exceeds 128. Bits pack MSB first; each row ends on a byte
// boundary with zero padding.
//
// Slave side: one pixel per beat in s_axis_tdata.
// Master side: one byte per beat, with its buffer offset; tlast marks the
//   final byte of the area, after which the next pixel starts a new area.
// Config: cfg_we_i writes the row width in pixels (index 0) or the row
//   count (index 1); either write restarts the area. Write only when idle.
//
// m_axis_tvalid rises once the pixel that completes a byte has passed
// the input register, then the output register. Throughput: one pixel
// per cycle while the master side does not stall, set by the input
// register feeding the output register through one compare/pack step.
// Reset: area 128 x 64, counters zero, both sides empty.
// Stall: a held result parks in the output register while the input
// register still takes one more pixel; then s_axis_tready drops until the
// master side accepts.
module rgb332_mono_threshold_packer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [rmtp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rmtp_pkg::CFG_W-1:0]        cfg_data_i,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rmtp_pkg::PIX_W-1:0]        s_axis_tdata,  // [7:0] pixel_color
  // packed byte output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rmtp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [7:0] packed_byte,
                                                           // [17:8] byte_offset,
                                                           // [23:18] zero
  output logic                              m_axis_tlast   // last_of_area
);

  rmtp_pkg::pix_t pix;
  rmtp_pkg::res_t res;
  logic           advance;

  rmtp_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .pix_o         (pix)
  );

  rmtp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix),
    .out_ready_i (m_axis_tready),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.byte_offset, res.packed_byte};
  assign m_axis_tlast = res.last_of_area;

endmodule

// ===== tb/rgb332_mono_threshold_packer_tb.sv =====
`timescale 1ns / 100ps

module rgb332_mono_threshold_packer_tb;

  import rmtp_pkg::*;

  // One packed output byte as the bitmap predictor sees it.
  typedef struct packed {
    logic [BYTE_W-1:0] bits;
    logic [OFF_W-1:0]  offset;
    logic              last;
  } mono_byte_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata;   // [7:0] pixel_color
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [7:0] packed_byte, [17:8] byte_offset
  logic                   m_axis_tlast;   // last_of_area

  rgb332_mono_threshold_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Bitmap predictor state: raw register values plus the packing position.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         cur_col;
  int unsigned         cur_row;
  logic [BYTE_W-1:0]   gather_bits;
  logic [OFF_W-1:0]    byte_slot;

  mono_byte_t  mono_bytes_due[$];   // predicted bytes, oldest first
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct   = 0;  // chance per cycle that the pixel side holds off
  int unsigned sink_idle_pct  = 0;  // chance per cycle that the byte side stalls

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a beat never shows up.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Zero reads as 1, anything above the parameter saturates.
  function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // Gray = (r8 + g8 + b8) / 3 with each channel scaled by truncating division.
  function automatic logic is_lit(input logic [PIX_W-1:0] color);
    int unsigned r8, g8, b8;
    r8 = (int'(color[7:5]) * 255) / 7;
    g8 = (int'(color[4:2]) * 255) / 7;
    b8 = (int'(color[1:0]) * 255) / 3;
    return ((r8 + g8 + b8) / 3) > 128;
  endfunction

  function automatic void restart_area();
    cur_col     = 0;
    cur_row     = 0;
    gather_bits = '0;
    byte_slot   = '0;
  endfunction

  // Advance the bitmap by one accepted pixel; queue a byte when one closes.
  function automatic void pack_pixel(input logic [PIX_W-1:0] color);
    int unsigned w, h;
    logic        row_end, area_end;
    w = eff_dim(32'(width_reg), MAX_COLUMNS);
    h = eff_dim(32'(height_reg), MAX_ROWS);
    row_end = (cur_col + 1 >= w);
    if (is_lit(color)) gather_bits |= 8'h80 >> cur_col[2:0];
    if (cur_col[2:0] != 3'd7 && !row_end) begin
      cur_col++;
      return;
    end
    area_end = row_end && (cur_row + 1 >= h);
    mono_bytes_due.push_back('{bits: gather_bits, offset: byte_slot, last: area_end});
    gather_bits = '0;
    if (area_end) begin
      restart_area();
    end else begin
      byte_slot++;
      if (row_end) begin
        cur_col = 0;
        cur_row++;
      end else begin
        cur_col++;
      end
    end
  endfunction

  // Byte side: random stall pattern, changed on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Byte side: compare every accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    mono_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mono_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte beat, got data %h last %b", $time,
                 m_axis_tdata[BYTE_W-1:0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = mono_bytes_due.pop_front();
        if (m_axis_tdata[BYTE_W-1:0] != want.bits) begin
          $display("%0t: packed_byte expected %h actual %h", $time, want.bits,
                   m_axis_tdata[BYTE_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[BYTE_W +: OFF_W] != want.offset) begin
          $display("%0t: byte_offset expected %0d actual %0d", $time, want.offset,
                   m_axis_tdata[BYTE_W +: OFF_W]);
          mismatch_count++;
        end
        if (m_axis_tlast != want.last) begin
          $display("%0t: last_of_area expected %b actual %b", $time, want.last,
                   m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Pixel side: one beat, with random hold-off before it.
  // tvalid stays high on return so back-to-back beats need no extra edge.
  task automatic send_pixel(input logic [PIX_W-1:0] color);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= color;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pack_pixel(color);
  endtask

  // Drop tvalid, let every predicted byte arrive, then wait out the input and
  // output registers so pixels that closed no byte are absorbed too.
  task automatic drain_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (mono_bytes_due.size() == 0);
    repeat (6) @(negedge clk_i);
  endtask

  // Single register write; the caller makes sure the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value[WIDTH_W-1:0];
    else                  height_reg = value[HEIGHT_W-1:0];
    restart_area();
  endtask

  task automatic set_area(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
    drain_block();
    write_reg(REG_WIDTH, w_raw);
    write_reg(REG_HEIGHT, h_raw);
  endtask

  // Mostly random colors, with plenty of all-off and all-on pixels.
  function automatic logic [PIX_W-1:0] pick_color();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Threshold neighbors and channel extremes in one 8-pixel row.
  // 6E sums to 388 and 8A to 387 (both just on), 6A and E5 just off.
  task automatic test_color_extremes();
    logic [PIX_W-1:0] row_pix[8] = '{8'h00, 8'hFF, 8'h6E, 8'h8A,
                                     8'h6A, 8'hE5, 8'hE0, 8'h1F};
    set_area(8'd8, 8'd1);
    foreach (row_pix[i]) send_pixel(row_pix[i]);
  endtask

  // Narrow rows pad to a byte; after the last byte a new area starts at 0.
  task automatic test_row_padding();
    set_area(8'd3, 8'd2);
    repeat (6) send_pixel(8'hFF);
    repeat (3) send_pixel(pick_color());
  endtask

  // Zero width and height act as 1; bit 7 of the height write is ignored.
  task automatic test_zero_dims();
    set_area(8'd0, 8'h80);
    send_pixel(8'hFF);
    send_pixel(8'h00);
  endtask

  // A write mid-byte drops the gathered bits and restarts the area.
  task automatic test_restart_on_write();
    set_area(8'd16, 8'd2);
    repeat (3) send_pixel(8'hFF);
    drain_block();
    write_reg(REG_WIDTH, 8'd4);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  // Oversized registers saturate to the parameters.
  task automatic test_saturated_area();
    set_area(8'd255, 8'd1);
    repeat (128) send_pixel(pick_color());
    set_area(8'd1, 8'hFF);
    repeat (64) send_pixel(pick_color());
    set_area(8'd128, 8'd2);
    repeat (256) send_pixel(pick_color());
  endtask

  // Random small areas, mostly complete; some end early before a rewrite.
  task automatic test_random_areas(input int unsigned budget, input int unsigned src_pct,
                                   input int unsigned sink_pct);
    int unsigned      sent, n_areas, pix_count;
    logic [CFG_W-1:0] w_raw, h_raw;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(19))
        0: begin
          w_raw = CFG_W'($urandom_range(129, 255));
          h_raw = CFG_W'($urandom_range(1, 2));
        end
        1: begin
          w_raw = CFG_W'($urandom_range(1, 4));
          h_raw = CFG_W'($urandom_range(65, 127));
        end
        2: begin
          w_raw = CFG_W'($urandom_range(2));
          h_raw = CFG_W'($urandom_range(2));
        end
        default: begin
          w_raw = CFG_W'($urandom_range(1, 24));
          h_raw = CFG_W'($urandom_range(1, 4));
        end
      endcase
      h_raw[7] = 1'($urandom_range(1));  // not part of the height register
      set_area(w_raw, h_raw);
      n_areas = $urandom_range(1, 3);
      for (int a = 0; a < n_areas; a++) begin
        pix_count = eff_dim(32'(w_raw), MAX_COLUMNS) * eff_dim(32'(h_raw[6:0]), MAX_ROWS);
        if (a == n_areas - 1 && $urandom_range(9) == 0)
          pix_count = $urandom_range(pix_count - 1);
        repeat (pix_count) send_pixel(pick_color());
        sent += pix_count;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    width_reg     = WIDTH_W'(MAX_COLUMNS);
    height_reg    = HEIGHT_W'(MAX_ROWS);
    restart_area();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed checks run under the first idling mix.
    src_idle_pct  = 15;
    sink_idle_pct = 74;
    test_color_extremes();
    test_row_padding();
    test_zero_dims();
    test_restart_on_write();
    test_saturated_area();

    test_random_areas(450, 15, 74);
    test_random_areas(450, 74, 15);
    test_random_areas(450, 0, 0);

    drain_block();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
